// File: sv/bps_pkg.sv
// Shared types, codes and the level-to-duty mapping of the buzzer pattern sequencer.
package bps_pkg;

  localparam int unsigned OpW      = 2;
  localparam int unsigned MaskW    = 4;
  localparam int unsigned PatW     = 3;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned ChIdxW   = 3;
  localparam int unsigned DutyW    = 9;
  localparam int unsigned PeriodW  = 10;
  localparam int unsigned PhaseW   = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned ReportCh = 4;

  localparam logic [OpW-1:0] OP_TICK = 2'd0;
  localparam logic [OpW-1:0] OP_MASK = 2'd1;
  localparam logic [OpW-1:0] OP_SET  = 2'd2;

  localparam logic [PatW-1:0] PAT_OFF  = 3'd0;
  localparam logic [PatW-1:0] PAT_CONT = 3'd1;
  localparam logic [PatW-1:0] PAT_FAST = 3'd2;
  localparam logic [PatW-1:0] PAT_SLOW = 3'd3;
  localparam logic [PatW-1:0] PAT_TAP  = 3'd4;

  localparam logic [PhaseW-1:0] PH_0 = 2'd0;
  localparam logic [PhaseW-1:0] PH_1 = 2'd1;
  localparam logic [PhaseW-1:0] PH_2 = 2'd2;
  localparam logic [PhaseW-1:0] PH_3 = 2'd3;

  localparam logic [CfgIdxW-1:0] CFG_FAST = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SLOW = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TAP  = 2'd2;

  localparam logic [PeriodW-1:0] FAST_RESET = 10'd200;
  localparam logic [PeriodW-1:0] SLOW_RESET = 10'd500;
  localparam logic [PeriodW-1:0] TAP_RESET  = 10'd100;

  localparam logic [LevelW-1:0] LEVEL_MAX = 8'd100;
  // ceil(2^19 / 25): exact quotient by 25 for dividends below 2^14
  localparam logic [14:0] RECIP_25 = 15'd20972;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [MaskW-1:0]  channel_mask;
    logic [PatW-1:0]   pattern;
    logic [LevelW-1:0] level;
    logic [ChIdxW-1:0] channel_index;
  } in_beat_t;

  typedef struct packed {
    logic [DutyW-1:0]    duty_ch0;
    logic [DutyW-1:0]    duty_ch1;
    logic [DutyW-1:0]    duty_ch2;
    logic [DutyW-1:0]    duty_ch3;
    logic [ReportCh-1:0] busy_mask;
  } out_beat_t;

  // min(lv,100) * 1023 / 200, division done as >>3 then multiply by reciprocal of 25
  function automatic logic [DutyW-1:0] level_to_duty(input logic [LevelW-1:0] lv);
    logic [6:0]  lc;
    logic [16:0] n;
    logic [28:0] p;
    lc = (lv > LEVEL_MAX) ? LEVEL_MAX[6:0] : lv[6:0];
    n  = {lc, 10'b0} - {10'b0, lc};
    p  = 29'(n[16:3]) * 29'(RECIP_25);
    return p[27:19];
  endfunction

endpackage

// File: sv/buzzer_pattern_sequencer.sv
// Buzzer pattern sequencer: per-channel pattern state, timing and duty report.
//
// Takes one beat per clock cycle unless the output stalls: a millisecond tick, a
// mask command or a single-channel set. All channels update in parallel in the
// cycle the beat is accepted, and the resulting duties and busy mask appear in the
// output register on the next cycle, one result per input beat. The input is ready
// whenever the output register is empty or is being drained in the same cycle, so
// throughput is one beat per cycle. The user must write the three period registers
// through the configuration port only while idle; the block does not enforce it.
module buzzer_pattern_sequencer import bps_pkg::*; #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [PeriodW-1:0]  cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_beat_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_beat_t           out_data_o
);

  logic [PeriodW-1:0] fast_q, slow_q, tap_q;

  logic [PatW-1:0]    pat_q   [CHANNELS];
  logic [PatW-1:0]    pat_d   [CHANNELS];
  logic [PhaseW-1:0]  phase_q [CHANNELS];
  logic [PhaseW-1:0]  phase_d [CHANNELS];
  logic [PeriodW-1:0] cnt_q   [CHANNELS];
  logic [PeriodW-1:0] cnt_d   [CHANNELS];
  logic [DutyW-1:0]   duty_q  [CHANNELS];
  logic [DutyW-1:0]   duty_d  [CHANNELS];
  logic [DutyW-1:0]   on_q    [CHANNELS];
  logic [DutyW-1:0]   on_d    [CHANNELS];

  logic               in_fire;
  logic [DutyW-1:0]   in_duty;
  logic [DutyW-1:0]   rep_duty [ReportCh];
  logic [ReportCh-1:0] rep_busy;
  out_beat_t          out_d, out_q;
  logic               out_valid_q;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign in_duty     = level_to_duty(in_data_i.level);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q <= FAST_RESET;
      slow_q <= SLOW_RESET;
      tap_q  <= TAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FAST: fast_q <= cfg_data_i;
        CFG_SLOW: slow_q <= cfg_data_i;
        CFG_TAP:  tap_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    logic sel;
    logic timed;
    logic [PeriodW-1:0] run_per;
    logic [PeriodW-1:0] start_per;

    if (c < MaskW) begin : g_sel
      assign sel = in_data_i.channel_mask[c];
    end else begin : g_nosel
      assign sel = 1'b0;
    end

    assign timed     = (pat_q[c] == PAT_FAST) || (pat_q[c] == PAT_SLOW) ||
                       (pat_q[c] == PAT_TAP);
    assign run_per   = (pat_q[c] == PAT_FAST) ? fast_q :
                       (pat_q[c] == PAT_SLOW) ? slow_q : tap_q;
    assign start_per = (in_data_i.pattern == PAT_FAST) ? fast_q :
                       (in_data_i.pattern == PAT_SLOW) ? slow_q : tap_q;

    always_comb begin
      pat_d[c]   = pat_q[c];
      phase_d[c] = phase_q[c];
      cnt_d[c]   = cnt_q[c];
      duty_d[c]  = duty_q[c];
      on_d[c]    = on_q[c];
      case (in_data_i.op)
        OP_TICK: begin
          if (timed) begin
            if (cnt_q[c] <= PeriodW'(1)) begin
              cnt_d[c] = '0;
              if (pat_q[c] == PAT_TAP) begin
                case (phase_q[c])
                  PH_0: begin
                    duty_d[c]  = on_q[c];
                    phase_d[c] = PH_1;
                    cnt_d[c]   = tap_q;
                  end
                  PH_1: begin
                    duty_d[c]  = '0;
                    phase_d[c] = PH_2;
                    cnt_d[c]   = tap_q;
                  end
                  PH_2: begin
                    duty_d[c]  = on_q[c];
                    phase_d[c] = PH_3;
                    cnt_d[c]   = tap_q;
                  end
                  default: begin
                    duty_d[c] = '0;
                    pat_d[c]  = PAT_OFF;
                  end
                endcase
              end else begin
                if (phase_q[c] == PH_0) begin
                  duty_d[c]  = on_q[c];
                  phase_d[c] = PH_1;
                end else begin
                  duty_d[c]  = '0;
                  phase_d[c] = PH_0;
                end
                cnt_d[c] = run_per;
              end
            end else begin
              cnt_d[c] = cnt_q[c] - PeriodW'(1);
            end
          end
        end
        OP_MASK: begin
          if (!sel || (in_data_i.pattern > PAT_TAP)) begin
            duty_d[c] = '0;
            pat_d[c]  = PAT_OFF;
          end
          if (sel) begin
            on_d[c]    = in_duty;
            phase_d[c] = PH_0;
            if (in_data_i.pattern <= PAT_TAP) begin
              pat_d[c] = in_data_i.pattern;
              if (in_data_i.pattern == PAT_OFF) begin
                duty_d[c] = '0;
              end else begin
                duty_d[c] = in_duty;
                if (in_data_i.pattern != PAT_CONT) begin
                  phase_d[c] = PH_1;
                  cnt_d[c]   = start_per;
                end
              end
            end
          end
        end
        OP_SET: begin
          if (in_data_i.channel_index == ChIdxW'(c)) begin
            duty_d[c] = in_duty;
            pat_d[c]  = PAT_CONT;
            on_d[c]   = in_duty;
          end
        end
        default: ;
      endcase
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pat_q[c]   <= PAT_OFF;
        phase_q[c] <= PH_0;
        cnt_q[c]   <= '0;
        duty_q[c]  <= '0;
        on_q[c]    <= '0;
      end else if (in_fire) begin
        pat_q[c]   <= pat_d[c];
        phase_q[c] <= phase_d[c];
        cnt_q[c]   <= cnt_d[c];
        duty_q[c]  <= duty_d[c];
        on_q[c]    <= on_d[c];
      end
    end

    assert property (@(posedge clk_i) disable iff (!rst_ni)
      (pat_q[c] == PAT_OFF) |-> (duty_q[c] == '0))
      else $error("channel off with nonzero duty");

    assert property (@(posedge clk_i) disable iff (!rst_ni)
      ((pat_q[c] == PAT_FAST) || (pat_q[c] == PAT_SLOW)) |-> (phase_q[c][1] == 1'b0))
      else $error("pulse pattern in tap phase");
  end

  for (genvar k = 0; k < ReportCh; k++) begin : g_rep
    if (k < CHANNELS) begin : g_present
      assign rep_duty[k] = duty_d[k];
      assign rep_busy[k] = (pat_d[k] != PAT_OFF);
    end else begin : g_absent
      assign rep_duty[k] = '0;
      assign rep_busy[k] = 1'b0;
    end
  end

  always_comb begin
    out_d.duty_ch0  = rep_duty[0];
    out_d.duty_ch1  = rep_duty[1];
    out_d.duty_ch2  = rep_duty[2];
    out_d.duty_ch3  = rep_duty[3];
    out_d.busy_mask = rep_busy;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted beat produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !in_fire)
    else $error("beat accepted over a pending result");

endmodule
